### design/s128_pkg.sv
// ----------------------------------------------------------------------------
// s128_pkg: shared types and codes for the signed wide ALU
// Holds the opcode enum and the request and result structs.
// ----------------------------------------------------------------------------
package s128_pkg;

    localparam int HALF_BITS = 64;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_NOT = 4'd7,
        OP_SHL = 4'd8,
        OP_SAR = 4'd9,
        OP_ROL = 4'd10,
        OP_ROR = 4'd11,
        OP_CMP = 4'd12
    } op_t;

    typedef struct packed {
        logic [3:0]           req_type;
        logic [HALF_BITS-1:0] a_lo;
        logic [HALF_BITS-1:0] a_hi;
        logic [HALF_BITS-1:0] b_lo;
        logic [HALF_BITS-1:0] b_hi;
    } req_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] result_lo;
        logic [HALF_BITS-1:0] result_hi;
        logic                 less_than;
        logic                 equal;
        logic                 divide_by_zero;
    } rsp_t;

endpackage

### design/s128_cell.sv
// ----------------------------------------------------------------------------
// s128_cell: one step of the multiply and divide chain
// Does one shift-and-add multiply step and one restoring divide step on the
// item it holds, then hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module s128_cell
    import s128_pkg::*;
#(
    parameter int W   = 128,
    parameter int IDX = 0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         vld_in,
    input  wire logic [W-1:0] prod_in,
    input  wire logic [W-1:0] mcand_in,
    input  wire logic [W-1:0] mplier_in,
    input  wire logic [W-1:0] rem_in,
    input  wire logic [W-1:0] quo_in,
    input  wire logic [W-1:0] dvsr_in,
    input  wire logic [W-1:0] side_in,
    output logic              vld_out,
    output logic [W-1:0]      prod_out,
    output logic [W-1:0]      mcand_out,
    output logic [W-1:0]      mplier_out,
    output logic [W-1:0]      rem_out,
    output logic [W-1:0]      quo_out,
    output logic [W-1:0]      dvsr_out,
    output logic [W-1:0]      side_out
);

    logic [W-1:0] prod_next;
    logic [W-1:0] rem_sh;
    logic [W:0]   diff;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;
    logic         vld_reg;

    always_comb
    begin
        prod_next = prod_in;
        if (mplier_in[IDX])
        begin
            prod_next = prod_in + (mcand_in << IDX);
        end
        rem_sh   = {rem_in[W-2:0], quo_in[W-1]};
        diff     = {1'b0, rem_sh} - {1'b0, dvsr_in};
        quo_next = {quo_in[W-2:0], 1'b0};
        rem_next = rem_sh;
        if (!diff[W] || rem_in[W-1])
        begin
            rem_next    = diff[W-1:0];
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_out   <= prod_next;
        mcand_out  <= mcand_in;
        mplier_out <= mplier_in;
        rem_out    <= rem_next;
        quo_out    <= quo_next;
        dvsr_out   <= dvsr_in;
        side_out   <= side_in;
    end

    assign vld_out = vld_reg;

endmodule
`default_nettype wire

### design/signed_128bit_alu.sv
// ----------------------------------------------------------------------------
// signed_128bit_alu: pipelined wide two's complement ALU
// Add, subtract, multiply, divide, logic, shifts, rotates and compare on WORD_BITS-bit
// operands.
// ----------------------------------------------------------------------------
// Usage: drive req and pulse start while busy is low; busy is always low, so
// a new item is taken every cycle. Each item yields one result on rsp, marked
// by a one-cycle done strobe. Each item passes the input register, the chain
// of WORD_BITS cells, each doing one multiply step and one divide step, and
// the output register. One item per cycle is sustained.
// Items leave in the order they entered. Reset clears every valid bit in the
// chain; items in flight are dropped. The receiver cannot stall: each result
// is shown for exactly one cycle. Shift counts come from b_lo.
// ----------------------------------------------------------------------------
`default_nettype none
module signed_128bit_alu
    import s128_pkg::*;
#(
    parameter int WORD_BITS = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);

    logic [2*HALF_BITS-1:0] a_raw, b_raw;
    logic [W-1:0] a, b, ma, mb, fast_res;
    logic         na, nb, lt, eq, is_div, dz;
    logic [HALF_BITS-1:0] cnt;
    logic [CW-1:0] sh, rk;

    // side word: fast result; flags travel in a separate tag register
    logic [W-1:0] prod  [0:W];
    logic [W-1:0] mcand [0:W];
    logic [W-1:0] mpl   [0:W];
    logic [W-1:0] rem   [0:W];
    logic [W-1:0] quo   [0:W];
    logic [W-1:0] dvsr  [0:W];
    logic [W-1:0] side  [0:W];
    logic         vld   [0:W];

    logic [7:0] tag_reg [0:W];
    logic [W-1:0] a_in_reg, b_in_reg;
    logic [3:0] op_in_reg;
    logic       vin_reg;

    logic [W-1:0] res;
    logic         done_reg;
    rsp_t         rsp_reg;

    assign a_raw = {req.a_hi, req.a_lo};
    assign b_raw = {req.b_hi, req.b_lo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= 1'b0;
        end
        else
        begin
            vin_reg <= start;
        end
    end

    logic [HALF_BITS-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        a_in_reg  <= a_raw[W-1:0];
        b_in_reg  <= b_raw[W-1:0];
        op_in_reg <= req.req_type;
        cnt_reg   <= req.b_lo;
    end

    assign a   = a_in_reg;
    assign b   = b_in_reg;
    assign cnt = cnt_reg;
    assign na  = a[W-1];
    assign nb  = b[W-1];
    assign ma  = na ? (~a + 1'b1) : a;
    assign mb  = nb ? (~b + 1'b1) : b;
    assign eq  = (a == b);
    assign lt  = $signed(a) < $signed(b);
    assign is_div = (op_in_reg == OP_DIV);
    assign dz  = is_div && (b == '0);
    assign sh  = cnt[CW-1:0];
    assign rk  = CW'(cnt % W);

    always_comb
    begin
        case (op_t'(op_in_reg))
            OP_ADD: fast_res = a + b;
            OP_SUB: fast_res = a - b;
            OP_AND: fast_res = a & b;
            OP_OR:  fast_res = a | b;
            OP_XOR: fast_res = a ^ b;
            OP_NOT: fast_res = ~a;
            OP_SHL: fast_res = (cnt < W) ? (a << sh) : '0;
            OP_SAR: fast_res = (cnt < W) ? W'($signed(a) >>> sh) : {W{a[W-1]}};
            OP_ROL: fast_res = W'({a, a} >> (W - int'(rk)));
            OP_ROR: fast_res = W'({a, a} >> rk);
            default: fast_res = '0;
        endcase
    end

    assign vld[0]   = vin_reg;
    assign prod[0]  = '0;
    assign mcand[0] = a;
    assign mpl[0]   = b;
    assign rem[0]   = '0;
    assign quo[0]   = ma;
    assign dvsr[0]  = mb;
    assign side[0]  = fast_res;
    assign tag_reg[0] = {op_in_reg, lt, eq, dz, na ^ nb};

    genvar i;
    generate
        for (i = 0; i < W; i++)
        begin : g_cell
            s128_cell #(.W(W), .IDX(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .vld_in     (vld[i]),
                .prod_in    (prod[i]),
                .mcand_in   (mcand[i]),
                .mplier_in  (mpl[i]),
                .rem_in     (rem[i]),
                .quo_in     (quo[i]),
                .dvsr_in    (dvsr[i]),
                .side_in    (side[i]),
                .vld_out    (vld[i+1]),
                .prod_out   (prod[i+1]),
                .mcand_out  (mcand[i+1]),
                .mplier_out (mpl[i+1]),
                .rem_out    (rem[i+1]),
                .quo_out    (quo[i+1]),
                .dvsr_out   (dvsr[i+1]),
                .side_out   (side[i+1])
            );
            always_ff @(posedge clk)
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    endgenerate

    always_comb
    begin
        case (op_t'(tag_reg[W][7:4]))
            OP_MUL:  res = prod[W];
            OP_DIV:  res = tag_reg[W][1] ? '0 :
                           (tag_reg[W][0] ? (~quo[W] + 1'b1) : quo[W]);
            default: res = side[W];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld[W];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.result_lo      <= HALF_BITS'(res);
        rsp_reg.result_hi      <= HALF_BITS'({{(2*HALF_BITS-W){1'b0}}, res} >> HALF_BITS);
        rsp_reg.less_than      <= tag_reg[W][3];
        rsp_reg.equal          <= tag_reg[W][2];
        rsp_reg.divide_by_zero <= tag_reg[W][1];
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

### design/s128_checker.sv
// ----------------------------------------------------------------------------
// s128_checker: port-level checks for the wide ALU
// Watches busy, the result strobe against accepted items, and the flags and result.
// ----------------------------------------------------------------------------
`default_nettype none
module s128_checker
    import s128_pkg::*;
#(
    parameter int WORD_BITS = 128
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(WORD_BITS + 2) done)
        else $error("result strobe missing for accepted item");

    a_eq_not_lt: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.equal && rsp.less_than))
        else $error("equal and less_than both set");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.divide_by_zero) |-> (rsp.result_lo == '0 && rsp.result_hi == '0))
        else $error("divide by zero gave nonzero result");

endmodule

bind signed_128bit_alu s128_checker #(.WORD_BITS(WORD_BITS)) u_s128_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
`default_nettype wire
